// ===== rtl/core/kvi_pkg.sv =====
// Shared types and constants for the keyframe vector interpolator.
package kvi_pkg;

	localparam int MAX_KEYS_DEF = 64;
	localparam int CFG_W = 7;
	localparam int IDX_W = 6;
	localparam int TIME_W = 32;
	localparam int VAL_W = 32;
	localparam int COMPS = 3;
	localparam int FRAC_W = 16;
	localparam int FAC_W = TIME_W + FRAC_W;
	localparam int HALF_W = FAC_W / 2;
	localparam int PROD_W = VAL_W + FAC_W;
	localparam int LIM_BIT = 50;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef logic [CFG_W-1:0] count_t;
	typedef logic [COMPS-1:0][VAL_W-1:0] vec_t;

	typedef struct packed {
		logic op;
		logic [IDX_W-1:0] key_index;
		logic [TIME_W-1:0] key_time;
		logic signed [VAL_W-1:0] value_x;
		logic signed [VAL_W-1:0] value_y;
		logic signed [VAL_W-1:0] value_z;
		logic [TIME_W-1:0] query_time;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_x;
		logic signed [VAL_W-1:0] out_y;
		logic signed [VAL_W-1:0] out_z;
		logic [IDX_W-1:0] segment;
		logic saturated;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic [FAC_W-1:0] dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [FAC_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/kvi_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
interface kvi_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/kvi_div.sv =====
// Restoring divider for the interpolation factor, one quotient bit per cycle.
module kvi_div (
	input logic clk,
	input logic arst_n,
	input kvi_pkg::div_req_t dreq,
	output kvi_pkg::div_rsp_t drsp
);
	import kvi_pkg::*;

	localparam int CNT_W = $clog2(FAC_W + 1);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [FAC_W-1:0] quo_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] dvs_q;

	logic [TIME_W:0] rem_sh;
	logic [TIME_W+1:0] diff;
	logic q_bit;

	assign rem_sh = {rem_q, quo_q[FAC_W-1]};
	assign diff = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign q_bit = ~diff[TIME_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(FAC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			quo_q <= dreq.dividend;
			rem_q <= '0;
			dvs_q <= dreq.divisor;
		end else if (busy_q) begin
			// keep the trial difference when it did not go negative
			rem_q <= q_bit ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
			quo_q <= {quo_q[FAC_W-2:0], q_bit};
		end
	end

	assign drsp.done = done_q;
	assign drsp.quotient = quo_q;

endmodule

// ===== rtl/core/keyframe_vector_interpolator_top.sv =====
// Keyframe vector interpolator: keyframe table in two memories, search, divide and lerp.
// A write word is accepted only while no query is in flight.
// A query holds the input through a search over the n keys in use, a fetch of both keys,
// a set-up step, the bit-serial divider and the shared 32x24 multiplier, then a load of the
// result; a zero factor skips the divider, one key also skips the search.
// Reset clears control and sets key_count to 1; the key memories are not cleared.
module keyframe_vector_interpolator_top #(
	parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
	input logic clk,
	input logic arst_n,
	kvi_stream_if.sink req,
	kvi_stream_if.source rsp,
	kvi_stream_if.sink cfg
);
	import kvi_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int R_W = LIM_BIT - FRAC_W + 2;
	localparam int MUL_W = VAL_W + HALF_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_LERP = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam logic [2:0] L_DIFF = 3'd0;
	localparam logic [2:0] L_MUL_LO = 3'd1;
	localparam logic [2:0] L_MUL_HI = 3'd2;
	localparam logic [2:0] L_SUM = 3'd3;
	localparam logic [2:0] L_ROUND = 3'd4;

	localparam logic [1:0] LAST_COMP = 2'(COMPS - 1);

	logic [TIME_W-1:0] time_mem [MAX_KEYS];
	vec_t vec_mem [MAX_KEYS];

	logic [2:0] state_q;
	logic [1:0] fc_q;
	logic [2:0] lstep_q;
	logic [1:0] comp_q;
	logic rsp_valid_q;
	logic chk_v_s1;
	logic [AW-1:0] chk_idx_s1;
	count_t key_count_q;

	logic [TIME_W-1:0] t_q;
	logic [CW-1:0] n_q;
	logic one_q;
	logic [CW-1:0] rd_idx_q;
	logic [AW-1:0] seg_q;
	logic [TIME_W-1:0] ts_q;
	logic [TIME_W-1:0] te_q;
	vec_t sv_q;
	vec_t ev_q;
	logic [FAC_W-1:0] fac_q;
	logic [VAL_W-1:0] mag_q;
	logic neg_q;
	logic [MUL_W-1:0] plo_q;
	logic [MUL_W-1:0] phi_q;
	logic [PROD_W-1:0] prod_q;
	vec_t res_q;
	logic sat_q;
	rsp_t rsp_q;

	logic [TIME_W-1:0] t_rdata;
	vec_t v_rdata;
	logic [AW-1:0] t_addr;
	logic [AW-1:0] v_addr;
	logic [AW-1:0] nx;

	logic req_fire;
	logic query_fire;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] n_clamp;
	logic issue;
	logic hit;
	logic last;
	logic t_ge;
	logic e_ge;
	logic [TIME_W-1:0] an;
	logic [TIME_W-1:0] ad;
	logic fac_zero;
	logic [VAL_W-1:0] s_c;
	logic [VAL_W-1:0] e_c;
	logic e_lt;
	logic [VAL_W-1:0] mag_c;
	logic [HALF_W-1:0] mul_op;
	logic [MUL_W-1:0] mul_out;
	logic [R_W-1:0] s_ext;
	logic [R_W-1:0] tt_ext;
	logic [R_W-1:0] r_sum;
	logic big;
	logic hi_ov;
	logic lo_ov;
	logic [VAL_W-1:0] r_fin;
	logic sat_c;
	logic out_free;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	assign req_fire = req.valid && req.ready;
	assign query_fire = req_fire && (req.data.op == OP_QUERY);
	assign wr_en = req_fire && (req.data.op == OP_WRITE)
		&& (32'(req.data.key_index) < 32'(MAX_KEYS));
	assign wr_addr = AW'(req.data.key_index);
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		if (key_count_q == '0) begin
			n_clamp = CW'(1);
		end else if (32'(key_count_q) > 32'(MAX_KEYS)) begin
			n_clamp = CW'(MAX_KEYS);
		end else begin
			n_clamp = CW'(key_count_q);
		end
	end

	// Memories: writes happen only in idle, read data is used only during a query, so no overlap.
	assign nx = seg_q + AW'(1);
	assign v_addr = (fc_q == 2'd0) ? seg_q : nx;
	assign t_addr = (state_q == ST_SEARCH) ? rd_idx_q[AW-1:0] : v_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_addr] <= req.data.key_time;
			vec_mem[wr_addr] <= {req.data.value_z, req.data.value_y, req.data.value_x};
		end
		t_rdata <= time_mem[t_addr];
		v_rdata <= vec_mem[v_addr];
	end

	// Search: one time read issued per cycle, checked in the cycle after it is issued.
	assign issue = (state_q == ST_SEARCH) && (rd_idx_q < n_q);
	assign hit = t_q < t_rdata;
	assign last = chk_idx_s1 == AW'(n_q - CW'(1));

	// Factor sign and magnitudes, from ordered compares.
	assign t_ge = t_q >= ts_q;
	assign e_ge = te_q >= ts_q;
	assign an = t_ge ? t_q - ts_q : ts_q - t_q;
	assign ad = e_ge ? te_q - ts_q : ts_q - te_q;
	assign fac_zero = one_q || (t_q == ts_q) || (te_q == ts_q) || (t_ge != e_ge);

	assign div_req.start = (state_q == ST_PREP) && !fac_zero;
	assign div_req.dividend = {an, {FRAC_W{1'b0}}};
	assign div_req.divisor = ad;

	kvi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.dreq(div_req),
		.drsp(div_rsp)
	);

	// Lerp datapath, one component at a time through a shared multiplier.
	assign s_c = sv_q[comp_q];
	assign e_c = ev_q[comp_q];
	assign e_lt = $signed(e_c) < $signed(s_c);
	assign mag_c = e_lt ? s_c - e_c : e_c - s_c;
	assign mul_op = (lstep_q == L_MUL_LO) ? fac_q[HALF_W-1:0] : fac_q[FAC_W-1:HALF_W];
	assign mul_out = mag_q * mul_op;

	assign s_ext = {{(R_W-VAL_W){s_c[VAL_W-1]}}, s_c};
	assign tt_ext = R_W'(prod_q[LIM_BIT-1:FRAC_W]);
	assign r_sum = neg_q ? s_ext - tt_ext : s_ext + tt_ext;
	assign big = prod_q[PROD_W-1:LIM_BIT] != '0;
	assign hi_ov = !r_sum[R_W-1] && (r_sum[R_W-2:VAL_W-1] != '0);
	assign lo_ov = r_sum[R_W-1] && (r_sum[R_W-2:VAL_W-1] != '1);

	always_comb begin
		sat_c = 1'b1;
		if (big) begin
			r_fin = neg_q ? VAL_MIN : VAL_MAX;
		end else if (hi_ov) begin
			r_fin = VAL_MAX;
		end else if (lo_ov) begin
			r_fin = VAL_MIN;
		end else begin
			r_fin = r_sum[VAL_W-1:0];
			sat_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= count_t'(1);
		end else if (cfg.valid && cfg.ready) begin
			key_count_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fc_q <= '0;
			lstep_q <= L_DIFF;
			comp_q <= '0;
			rsp_valid_q <= 1'b0;
			chk_v_s1 <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					chk_v_s1 <= 1'b0;
					if (query_fire) begin
						state_q <= (n_clamp == CW'(1)) ? ST_FETCH : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (chk_v_s1 && (hit || last)) begin
						state_q <= ST_FETCH;
						chk_v_s1 <= 1'b0;
					end else begin
						chk_v_s1 <= issue;
					end
				end
				ST_FETCH: begin
					if (fc_q == 2'd2) begin
						fc_q <= '0;
						state_q <= ST_PREP;
					end else begin
						fc_q <= fc_q + 2'd1;
					end
				end
				ST_PREP: begin
					state_q <= fac_zero ? ST_LERP : ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					if (lstep_q == L_ROUND) begin
						lstep_q <= L_DIFF;
						if (comp_q == LAST_COMP) begin
							comp_q <= '0;
							state_q <= ST_DONE;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						lstep_q <= lstep_q + 3'd1;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (query_fire) begin
					t_q <= req.data.query_time;
					n_q <= n_clamp;
					one_q <= (n_clamp == CW'(1));
					rd_idx_q <= CW'(1);
					seg_q <= '0;
					sat_q <= 1'b0;
				end
			end
			ST_SEARCH: begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				chk_idx_s1 <= rd_idx_q[AW-1:0];
				if (chk_v_s1 && hit) begin
					seg_q <= chk_idx_s1 - AW'(1);
				end
			end
			ST_FETCH: begin
				if (fc_q == 2'd1) begin
					ts_q <= t_rdata;
					sv_q <= v_rdata;
				end else if (fc_q == 2'd2) begin
					te_q <= t_rdata;
					ev_q <= v_rdata;
				end
			end
			ST_PREP: begin
				if (fac_zero) begin
					fac_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					fac_q <= div_rsp.quotient;
				end
			end
			ST_LERP: begin
				case (lstep_q)
					L_DIFF: begin
						// one key in use: drop the end key, it may never have been written
						mag_q <= one_q ? '0 : mag_c;
						neg_q <= !one_q && e_lt;
					end
					L_MUL_LO: plo_q <= mul_out;
					L_MUL_HI: phi_q <= mul_out;
					L_SUM: prod_q <= PROD_W'(plo_q) + {phi_q, {HALF_W{1'b0}}};
					L_ROUND: begin
						res_q[comp_q] <= r_fin;
						if (sat_c) begin
							sat_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_q.out_x <= res_q[0];
					rsp_q.out_y <= res_q[1];
					rsp_q.out_z <= res_q[2];
					rsp_q.segment <= IDX_W'(seg_q);
					rsp_q.saturated <= sat_q;
				end
			end
			default: ;
		endcase
	end

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LERP |-> one_q || (CW'(seg_q) + CW'(1) < n_q))
		else $error("segment end key beyond keys in use");

	a_one_key_fac: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LERP && one_q |-> fac_q == '0)
		else $error("nonzero factor with a single key");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("finished query not moved to the output register");

endmodule
